@@ hdl/imf_pkg.sv @@
package imf_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned WINDOW_DEF    = 3;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;

  // Configuration register widths and reset values.
  localparam int unsigned WIDTH_REG_W   = 11;
  localparam int unsigned HEIGHT_REG_W  = 13;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned ROW_W         = 12;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(512);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // Control that travels with a window through the sorting chain.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

@@ hdl/imf_ifs.sv @@
interface imf_pix_if;
  import imf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface imf_med_if;
  import imf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_value;
  logic             frame_last;

  modport source (output valid, output median_value, output frame_last, input ready);
  modport sink (input valid, input median_value, input frame_last, output ready);
endinterface

@@ hdl/imf_line_buf.sv @@
module imf_line_buf import imf_pkg::*; #(
  parameter int unsigned DEPTH = MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(MAX_WIDTH_DEF),
  parameter int unsigned DW    = (WINDOW_DEF - 1) * PIX_W
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read so a stalled column stays intact.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/imf_col_cell.sv @@
module imf_col_cell import imf_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic [WINDOW*PIX_W-1:0] col_i,
  output logic [WINDOW*PIX_W-1:0] col_o
);

  logic [WINDOW*PIX_W-1:0] col_q;
  logic [WINDOW*PIX_W-1:0] col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

@@ hdl/imf_sort_cell.sv @@
module imf_sort_cell import imf_pkg::*; #(
  parameter int unsigned N   = WINDOW_DEF * WINDOW_DEF,
  parameter bit          ODD = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stage_ctl_t         in_ctl_i,
  output logic               in_ready_o,
  input  logic [N*PIX_W-1:0] in_vec_i,
  output stage_ctl_t         out_ctl_o,
  input  logic               out_ready_i,
  output logic [N*PIX_W-1:0] out_vec_o
);

  logic [N*PIX_W-1:0] vec_q;
  logic [N*PIX_W-1:0] vec_d;
  logic               valid_q;
  logic               last_q;
  logic               load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_ctl_i.valid && in_ready_o;

  // One round of odd-even transposition: disjoint neighbor pairs swap if out of order.
  always_comb begin
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    vec_d = in_vec_i;
    for (int i = int'(ODD); i + 1 < int'(N); i += 2) begin
      a = in_vec_i[i*PIX_W +: PIX_W];
      b = in_vec_i[(i+1)*PIX_W +: PIX_W];
      if (a > b) begin
        vec_d[i*PIX_W +: PIX_W]     = b;
        vec_d[(i+1)*PIX_W +: PIX_W] = a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vec_q  <= vec_d;
      last_q <= in_ctl_i.last;
    end
  end

  assign out_ctl_o.valid = valid_q;
  assign out_ctl_o.last  = last_q;
  assign out_vec_o       = vec_q;

endmodule

@@ hdl/image_median_filter_core.sv @@
// Streaming WINDOW x WINDOW median filter for 8-bit grayscale frames in raster order.
// One pixel is taken per clock while the output is not held off; the line buffer does
// one read and one write per pixel and the sorting chain of WINDOW*WINDOW registered
// compare-exchange cells takes a new window every cycle when not stalled, so the
// sustained rate is one pixel per clock without back-pressure. Results, registered in
// the fetch stage and each sort cell, come only for centers at least WINDOW/2 pixels
// from every edge, with frame_last on the frame's final one.
// Writing either size register restarts the frame; write it only while the block is
// idle. The line buffer has no clearing pass and needs no time after reset.
module image_median_filter_core import imf_pkg::*; #(
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  imf_pix_if.sink               in_if,
  imf_med_if.source             out_if
);

  localparam int unsigned CELLS  = WINDOW * WINDOW;
  localparam int unsigned LINES  = WINDOW - 1;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W  = COL_W + 1;
  localparam int unsigned CMP_W  = (DIM_W > WIDTH_REG_W) ? DIM_W : WIDTH_REG_W;
  localparam int unsigned WORD_W = LINES * PIX_W;
  localparam int unsigned COLV_W = WINDOW * PIX_W;
  localparam int unsigned VEC_W  = CELLS * PIX_W;

  // Configuration and position counters.
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [COL_W-1:0]        col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [CMP_W-1:0]        w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic                    cfg_hit;
  logic                    col_end, row_end;
  logic                    in_fire;

  // Column fetch stage.
  logic              f1_v_q;
  logic [PIX_W-1:0]  f1_pix_q;
  logic [COL_W-1:0]  f1_col_q;
  logic              f1_emit_q;
  logic              f1_last_q;
  logic              f1_fwd_q;
  logic [WORD_W-1:0] f1_fwd_word_q;
  logic              f1_go;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] old_word;
  logic [COLV_W-1:0] column_in;
  logic [WORD_W-1:0] new_word;

  logic [COLV_W-1:0] win_col [WINDOW];
  logic [VEC_W-1:0]  next_win;

  stage_ctl_t        sort_ctl [CELLS+1];
  logic [VEC_W-1:0]  sort_vec [CELLS+1];
  logic [CELLS:0]    sort_rdy;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one and oversized values saturate.
  always_comb begin
    priority if (width_q == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(width_q);
    end
    priority if (height_q == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign in_fire = in_if.valid && in_if.ready;
  assign col_end = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
  assign row_end = (HEIGHT_REG_W'(row_q) + HEIGHT_REG_W'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The fetch stage leaves when the sorting chain can take its window, or at once
  // when its pixel produces no result.
  assign f1_go       = f1_v_q && (!f1_emit_q || sort_rdy[0]);
  assign in_if.ready = !f1_v_q || f1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (in_if.ready) begin
      f1_v_q <= in_if.valid;
    end
  end

  // A pixel in the same column as the one leaving the fetch stage (very narrow
  // frames) must see that column's new contents, not the stale memory word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      f1_pix_q      <= in_if.pixel_value;
      f1_col_q      <= col_q;
      f1_emit_q     <= (row_q >= ROW_W'(WINDOW - 1)) && (col_q >= COL_W'(WINDOW - 1));
      f1_last_q     <= col_end && row_end;
      f1_fwd_q      <= f1_v_q && (f1_col_q == col_q);
      f1_fwd_word_q <= new_word;
    end
  end

  imf_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (WORD_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (f1_go),
    .wr_addr_i (f1_col_q),
    .wr_data_i (new_word)
  );

  // Oldest row sits in the low byte; each line moves up by one row.
  assign old_word  = f1_fwd_q ? f1_fwd_word_q : rd_word;
  assign column_in = {f1_pix_q, old_word};
  assign new_word  = column_in[COLV_W-1:PIX_W];

  for (genvar c = 0; c < WINDOW; c++) begin : g_win
    logic [COLV_W-1:0] col_next;
    if (c == WINDOW - 1) begin : g_edge
      assign col_next = column_in;
    end else begin : g_inner
      assign col_next = win_col[c+1];
    end
    assign next_win[c*COLV_W +: COLV_W] = col_next;

    imf_col_cell #(
      .WINDOW (WINDOW)
    ) u_col_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (f1_go),
      .col_i   (col_next),
      .col_o   (win_col[c])
    );
  end

  assign sort_ctl[0].valid = f1_v_q && f1_emit_q;
  assign sort_ctl[0].last  = f1_last_q;
  assign sort_vec[0]       = next_win;
  assign sort_rdy[CELLS]   = out_if.ready;

  for (genvar s = 0; s < CELLS; s++) begin : g_sort
    imf_sort_cell #(
      .N   (CELLS),
      .ODD (s % 2 == 1)
    ) u_sort_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_ctl_i    (sort_ctl[s]),
      .in_ready_o  (sort_rdy[s]),
      .in_vec_i    (sort_vec[s]),
      .out_ctl_o   (sort_ctl[s+1]),
      .out_ready_i (sort_rdy[s+1]),
      .out_vec_o   (sort_vec[s+1])
    );
  end

  assign out_if.valid        = sort_ctl[CELLS].valid;
  assign out_if.frame_last   = sort_ctl[CELLS].last;
  assign out_if.median_value = sort_vec[CELLS][(CELLS/2)*PIX_W +: PIX_W];

endmodule

@@ test/image_median_filter_core_test.sv @@
module image_median_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import imf_pkg::*;

  localparam int unsigned WIN       = WINDOW_DEF;
  localparam int unsigned LINES     = WIN - 1;
  localparam int unsigned CELLS     = WIN * WIN;
  localparam int unsigned LATENCY   = CELLS + 2;
  localparam int unsigned SETTLE    = 2 * LATENCY + 4;
  localparam int unsigned MAX_SHOWN = 10;

  // Register indexes that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  typedef enum int unsigned {
    PIX_UNIFORM,
    PIX_CLUSTER,
    PIX_IMPULSE,
    PIX_BINARY
  } pixel_mix_e;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last;
  } median_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  imf_pix_if pix_bus ();
  imf_med_if med_bus ();

  image_median_filter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (pix_bus),
    .out_if     (med_bus)
  );

  // Filter state as the block should hold it.
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [PIX_W-1:0]        line_store [LINES][MAX_WIDTH_DEF];
  logic [PIX_W-1:0]        win_regs [WIN][WIN];
  int unsigned             col_cnt;
  int unsigned             row_cnt;

  median_result_t median_expected[$];
  int unsigned    error_count;
  int unsigned    burst_left;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (int'(width_reg) > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (int'(height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic void reset_filter_state();
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_cnt    = 0;
    row_cnt    = 0;
    foreach (line_store[r, c]) line_store[r][c] = '0;
    foreach (win_regs[r, c]) win_regs[r][c] = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data[WIDTH_REG_W-1:0];
        col_cnt   = 0;
        row_cnt   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[HEIGHT_REG_W-1:0];
        col_cnt    = 0;
        row_cnt    = 0;
      end
      default: ;
    endcase
  endfunction

  // The median is the value whose rank range covers the middle position.
  function automatic logic [PIX_W-1:0] window_median();
    logic [PIX_W-1:0] cells [CELLS];
    int unsigned      less;
    int unsigned      same;
    foreach (win_regs[r, c]) cells[r * WIN + c] = win_regs[r][c];
    for (int i = 0; i < CELLS; i++) begin
      less = 0;
      same = 0;
      for (int j = 0; j < CELLS; j++) begin
        if (cells[j] < cells[i]) less++;
        else if (cells[j] == cells[i]) same++;
      end
      if (less <= CELLS / 2 && less + same > CELLS / 2) return cells[i];
    end
    return '0;
  endfunction

  function automatic bit predict_pixel(logic [PIX_W-1:0] pix, output median_result_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    int unsigned      row;
    logic [PIX_W-1:0] column_new [WIN];
    bit               made;
    w   = eff_width();
    h   = eff_height();
    col = (col_cnt >= w) ? 0 : col_cnt;
    row = (row_cnt >= h) ? 0 : row_cnt;
    for (int r = 0; r < LINES; r++) column_new[r] = line_store[r][col];
    column_new[LINES] = pix;
    for (int r = 0; r < LINES - 1; r++) line_store[r][col] = column_new[r + 1];
    line_store[LINES - 1][col] = pix;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) win_regs[r][c] = win_regs[r][c + 1];
      win_regs[r][WIN - 1] = column_new[r];
    end
    made = (row >= WIN - 1) && (col >= WIN - 1);
    res  = '0;
    if (made) begin
      res.median = window_median();
      res.last   = (row == h - 1) && (col == w - 1);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
    return made;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(pixel_mix_e mix, logic [PIX_W-1:0] base);
    case (mix)
      PIX_CLUSTER: return base + PIX_W'($urandom_range(0, 3));
      PIX_IMPULSE: begin
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return base;
      end
      PIX_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("image_median_filter_core_test: errors");
    $finish;
  end

  // Result side: the ready pattern switches between several stall styles.
  initial begin
    int unsigned ready_mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned phase;
    logic        ready_next;
    ready_mode = 0;
    mode_left  = 0;
    stall_left = 0;
    phase      = 0;
    med_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(64, 512);
      end
      mode_left--;
      phase++;
      case (ready_mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 3) != 0);
        2: begin
          if (stall_left > 0) begin
            ready_next = 1'b0;
            stall_left--;
          end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 16);
          end
        end
        default: ready_next = (phase % 3 != 0);
      endcase
      med_bus.ready <= ready_next;
    end
  end

  // Sampling at the falling edge sees settled values of the coming transfer.
  initial begin
    median_result_t want;
    median_result_t got;
    forever begin
      @(negedge clk_i);
      if (rst_ni && med_bus.valid === 1'b1 && med_bus.ready) begin
        got.median = med_bus.median_value;
        got.last   = med_bus.frame_last;
        if (median_expected.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("%0t: result with nothing expected: median %0d frame_last %0b",
                     $realtime, got.median, got.last);
        end else begin
          want = median_expected.pop_front();
          if (got.median !== want.median || got.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
              $display("%0t: median %0d frame_last %0b, expected median %0d frame_last %0b",
                       $realtime, got.median, got.last, want.median, want.last);
          end
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_pixel(logic [PIX_W-1:0] value);
    int unsigned    gap;
    bit             took;
    median_result_t res;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(8, 20);
        default: gap = $urandom_range(1, 4);
      endcase
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      if (gap > 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= value;
    do begin
      @(negedge clk_i);
      took = pix_bus.valid && pix_bus.ready;
      @(posedge clk_i);
    end while (!took);
    if (predict_pixel(value, res)) median_expected.push_back(res);
  endtask

  task automatic send_pixels(int unsigned count, pixel_mix_e mix);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom_range(0, 255));
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mix, base));
  endtask

  // Some pixels make no result, so the pipeline gets extra time after the last one.
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (median_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // The write strobe drops for one cycle so that writes in a row never collide.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    apply_reg_write(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_size(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, wdata);
    write_reg(REG_IMAGE_HEIGHT, hdata);
  endtask

  // Sizes after reset: two full rows and a few interior centers of the third.
  task automatic test_reset_sizes();
    send_pixels(2 * WIDTH_RST + 6, PIX_UNIFORM);
  endtask

  // Three back-to-back 3x3 frames: extremes, single set bits plus all ones, and ties.
  task automatic test_directed_frames();
    logic [PIX_W-1:0] pix [27];
    pix = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
            8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFF,
            8'd9,  8'd9,  8'd200, 8'd9, 8'd9,  8'd200, 8'd200, 8'd200, 8'd9};
    set_size(13'd3, 13'd3);
    foreach (pix[i]) send_pixel(pix[i]);
  endtask

  task automatic test_size_limits();
    // A zero size acts as one; frames below the window size give nothing.
    set_size(13'd0, 13'd0);
    send_pixels(5, PIX_UNIFORM);
    set_size(13'd0, 13'd5);
    send_pixels(10, PIX_UNIFORM);
    set_size(13'd2, 13'd9);
    send_pixels(18, PIX_BINARY);
    set_size(13'd9, 13'd2);
    send_pixels(18, PIX_BINARY);
    // Only the low width bits count, so this width acts as three.
    set_size(13'h1803, 13'd3);
    send_pixels(18, PIX_IMPULSE);
    // An oversized width saturates, so a long first row gives no result.
    set_size(13'h1FFF, 13'd3);
    send_pixels(80, PIX_IMPULSE);
    // An oversized height saturates, so results run on well past small heights.
    set_size(13'd3, 13'h1FFF);
    send_pixels(3 * 40, PIX_CLUSTER);
  endtask

  task automatic test_mid_frame_writes();
    // Unmapped indexes must not restart the frame.
    set_size(13'd5, 13'd5);
    send_pixels(12, PIX_UNIFORM);
    wait_idle();
    write_reg(REG_UNMAPPED_LO, 13'h1FFF);
    write_reg(REG_UNMAPPED_HI, 13'h0000);
    send_pixels(13, PIX_UNIFORM);
    // A size write in the middle of a frame starts the next one from the top.
    set_size(13'd4, 13'd4);
    send_pixels(7, PIX_CLUSTER);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 13'd4);
    send_pixels(16, PIX_CLUSTER);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned choice;
    bit          first;
    sent  = 0;
    first = 1'b1;
    while (sent < 500) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      h = $urandom_range(3, 8);
      if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 2);
      if ($urandom_range(0, 19) == 0) h = $urandom_range(0, 2);
      choice = first ? 0 : $urandom_range(0, 3);
      if (choice == 2 && eff_height() > 8) choice = 0;
      first = 1'b0;
      wait_idle();
      case (choice)
        0: begin
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        end
        1: begin
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        end
        2: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        default: begin
          write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                    CFG_DATA_W'($urandom_range(0, 8191)));
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        end
      endcase
      // Mostly whole frames; now and then one is cut short by the next size write.
      if ($urandom_range(0, 3) == 0 && eff_width() * eff_height() > 1)
        n = $urandom_range(1, eff_width() * eff_height() - 1);
      else
        n = eff_width() * eff_height() * $urandom_range(1, 2);
      send_pixels(n, pixel_mix_e'($urandom_range(0, 3)));
      sent += n;
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_IMAGE_WIDTH;
    cfg_data            <= '0;
    pix_bus.valid       <= 1'b0;
    pix_bus.pixel_value <= '0;
    error_count = 0;
    burst_left  = 0;
    reset_filter_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_sizes();
    test_directed_frames();
    test_size_limits();
    test_mid_frame_writes();
    test_random_frames();
    wait_idle();
    if (error_count == 0) begin
      $display("image_median_filter_core_test: clean");
    end else begin
      $display("image_median_filter_core_test: errors");
    end
    $finish;
  end

endmodule

@@ image_median_filter_core.f @@
hdl/imf_pkg.sv
hdl/imf_ifs.sv
hdl/imf_line_buf.sv
hdl/imf_col_cell.sv
hdl/imf_sort_cell.sv
hdl/image_median_filter_core.sv
test/image_median_filter_core_test.sv
